FILE: hdl/psi_pkg.sv
// Shared types and constants of the piecewise size interpolator.
package psi_pkg;

    // Interpretation modes.
    localparam logic [1:0] MODE_DISCRETE = 2'd0;
    localparam logic [1:0] MODE_LINEAR   = 2'd1;
    localparam logic [1:0] MODE_ATTR     = 2'd2;
    localparam logic [1:0] MODE_CONST    = 2'd3;

    // Request opcodes.
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KIND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd3;

    // Pipeline depth of the divider and square root units.
    localparam int DIV_STAGES  = 32;
    localparam int SQRT_STAGES = 16;

    // Per-request information that rides along the arithmetic pipeline.
    typedef struct packed {
        logic        err;
        logic        interp;
        logic        kind;
        logic        scale_en;
        logic [31:0] direct;
    } side_t;

endpackage

FILE: hdl/psi_divsqrt.sv
// Pipelined long divider followed by a pipelined integer square root.
module psi_divsqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vld_in,
    input  psi_pkg::side_t  side_in,
    input  logic [63:0]     num_in,
    input  logic [31:0]     span_in,
    output logic            vld_out,
    output psi_pkg::side_t  side_out,
    output logic [15:0]     quot_out,
    output logic [15:0]     root_out
);
    import psi_pkg::*;

    // Divider stage registers: remainder, numerator low bits turning into quotient.
    logic        div_vld_reg  [0:DIV_STAGES-1];
    side_t       div_side_reg [0:DIV_STAGES-1];
    logic [31:0] div_rem_reg  [0:DIV_STAGES-1];
    logic [31:0] div_nlo_reg  [0:DIV_STAGES-1];
    logic [31:0] div_span_reg [0:DIV_STAGES-1];

    // Square root stage registers.
    logic        sq_vld_reg  [0:SQRT_STAGES-1];
    side_t       sq_side_reg [0:SQRT_STAGES-1];
    logic [31:0] sq_x_reg    [0:SQRT_STAGES-1];
    logic [17:0] sq_rem_reg  [0:SQRT_STAGES-1];
    logic [15:0] sq_root_reg [0:SQRT_STAGES-1];
    logic [15:0] sq_quot_reg [0:SQRT_STAGES-1];

    genvar j;

    // Restoring division, one quotient bit per stage.
    generate
        for (j = 0; j < DIV_STAGES; j++) begin : g_div
            logic        vld_i;
            side_t       side_i;
            logic [31:0] rem_i;
            logic [31:0] nlo_i;
            logic [31:0] span_i;
            logic [32:0] shifted;
            logic        ge;
            logic [32:0] diff;

            if (j == 0) begin : g_first
                assign vld_i  = vld_in;
                assign side_i = side_in;
                assign rem_i  = num_in[63:32];
                assign nlo_i  = num_in[31:0];
                assign span_i = span_in;
            end
            else begin : g_rest
                assign vld_i  = div_vld_reg[j-1];
                assign side_i = div_side_reg[j-1];
                assign rem_i  = div_rem_reg[j-1];
                assign nlo_i  = div_nlo_reg[j-1];
                assign span_i = div_span_reg[j-1];
            end

            assign shifted = {rem_i, nlo_i[31]};
            assign diff    = shifted - {1'b0, span_i};
            assign ge      = (shifted >= {1'b0, span_i});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_vld_reg[j] <= 1'b0;
                end
                else
                begin
                    div_vld_reg[j] <= vld_i;
                end
            end

            always_ff @(posedge clk)
            begin
                div_side_reg[j] <= side_i;
                div_span_reg[j] <= span_i;
                div_rem_reg[j]  <= ge ? diff[31:0] : shifted[31:0];
                div_nlo_reg[j]  <= {nlo_i[30:0], ge};
            end
        end
    endgenerate

    // Bit-by-bit square root, one root bit per stage.
    generate
        for (j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
            logic        vld_i;
            side_t       side_i;
            logic [31:0] x_i;
            logic [17:0] rem_i;
            logic [15:0] root_i;
            logic [15:0] quot_i;
            logic [19:0] cur;
            logic [19:0] trial;
            logic [19:0] diff;
            logic        ge;

            if (j == 0) begin : g_first
                assign vld_i  = div_vld_reg[DIV_STAGES-1];
                assign side_i = div_side_reg[DIV_STAGES-1];
                assign x_i    = div_nlo_reg[DIV_STAGES-1];
                assign rem_i  = '0;
                assign root_i = '0;
                assign quot_i = div_nlo_reg[DIV_STAGES-1][15:0];
            end
            else begin : g_rest
                assign vld_i  = sq_vld_reg[j-1];
                assign side_i = sq_side_reg[j-1];
                assign x_i    = sq_x_reg[j-1];
                assign rem_i  = sq_rem_reg[j-1];
                assign root_i = sq_root_reg[j-1];
                assign quot_i = sq_quot_reg[j-1];
            end

            assign cur   = {rem_i, x_i[31:30]};
            assign trial = {2'b00, root_i, 2'b01};
            assign ge    = (cur >= trial);
            assign diff  = cur - trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_vld_reg[j] <= 1'b0;
                end
                else
                begin
                    sq_vld_reg[j] <= vld_i;
                end
            end

            always_ff @(posedge clk)
            begin
                sq_side_reg[j] <= side_i;
                sq_quot_reg[j] <= quot_i;
                sq_x_reg[j]    <= {x_i[29:0], 2'b00};
                sq_rem_reg[j]  <= ge ? diff[17:0] : cur[17:0];
                sq_root_reg[j] <= {root_i[14:0], ge};
            end
        end
    endgenerate

    assign vld_out  = sq_vld_reg[SQRT_STAGES-1];
    assign side_out = sq_side_reg[SQRT_STAGES-1];
    assign quot_out = sq_quot_reg[SQRT_STAGES-1];
    assign root_out = sq_root_reg[SQRT_STAGES-1];

endmodule

FILE: hdl/piecewise_size_interpolator_core.sv
// Top level of the piecewise size interpolator: table, front stages and output scaling.
//
// Every request is taken in the cycle start is high (busy stays low), one per clock, and
// each classify request yields exactly one result, strobed by done for a single cycle;
// table writes yield none. Each classify request passes through four front stages, the
// 32-stage divider, the 16-stage square root and the output register. Results cannot be
// held off. The user must write configuration only while no request is in flight (the
// block itself does not enforce it); table writes take effect for the next request.
module piecewise_size_interpolator_core #(
    parameter int TABLE_DEPTH     = 8,
    parameter int VALUE_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic [2:0]                      entry_index,
    input  logic signed [31:0]              entry_threshold,
    input  logic [15:0]                     entry_size,
    input  logic signed [31:0]              sample_value,
    input  logic                            cfg_write,
    input  logic [psi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psi_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            done,
    output logic signed [31:0]              out_size,
    output logic                            empty_error
);
    import psi_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ASHIFT  = VALUE_FRAC_BITS + 8;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic        kind_reg;
    logic [15:0] scale_reg;
    logic [3:0]  count_reg;

    // Breakpoint table.
    logic signed [31:0] thr_reg  [0:TABLE_DEPTH-1];
    logic [15:0]        size_reg [0:TABLE_DEPTH-1];

    logic               accept;
    logic [CNT_W-1:0]   n_eff;
    logic [TABLE_DEPTH-1:0] lt;
    logic               found_next;
    logic [IDX_W-1:0]   first_next;

    // The block never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DISCRETE;
            kind_reg  <= 1'b0;
            scale_reg <= 16'd256;
            count_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_KIND:  kind_reg  <= cfg_data[0];
                REG_SCALE: scale_reg <= cfg_data[15:0];
                REG_COUNT: count_reg <= cfg_data[3:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // Table write requests; slots beyond the table are ignored.
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_WRITE))
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (32'(entry_index) == i)
                begin
                    thr_reg[i]  <= entry_threshold;
                    size_reg[i] <= entry_size;
                end
            end
        end
    end

    // Number of entries in use, clamped to the table depth.
    assign n_eff = (32'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_reg);

    // Threshold compare on the incoming sample and search for the first threshold above it.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            lt[i] = (i < int'(n_eff)) && (sample_value < thr_reg[i]);
        end
        found_next = |lt;
        first_next = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (lt[i])
            begin
                first_next = IDX_W'(i);
            end
        end
    end

    // Stage 1: search result.
    logic               s1_valid_reg;
    logic signed [31:0] s1_v_reg;
    logic               s1_found_reg;
    logic [IDX_W-1:0]   s1_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (opcode == OP_CLASSIFY);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg     <= sample_value;
        s1_found_reg <= found_next;
        s1_first_reg <= first_next;
    end

    // Stage 2: fetch the breakpoints and pick the case.
    logic [IDX_W-1:0]   lo_idx;
    logic [IDX_W-1:0]   last_idx;
    logic               attr_next;
    logic               empty_next;
    logic               interp_next;
    logic [15:0]        dsize_next;

    assign lo_idx     = s1_first_reg - 1'b1;
    assign last_idx   = IDX_W'(n_eff - 1'b1);
    assign attr_next  = (mode_reg == MODE_ATTR);
    assign empty_next = (n_eff == '0);
    assign interp_next = !attr_next && !empty_next && (mode_reg == MODE_LINEAR)
                         && s1_found_reg && (s1_first_reg != '0);

    always_comb
    begin
        priority if (mode_reg == MODE_CONST)
        begin
            dsize_next = size_reg[0];
        end
        else if (!s1_found_reg)
        begin
            dsize_next = size_reg[last_idx];
        end
        else if (s1_first_reg == '0)
        begin
            dsize_next = size_reg[0];
        end
        else
        begin
            dsize_next = size_reg[lo_idx];
        end
    end

    logic               s2_valid_reg;
    logic signed [31:0] s2_v_reg;
    logic signed [31:0] s2_lo_reg;
    logic signed [31:0] s2_up_reg;
    logic [15:0]        s2_sl_reg;
    logic [15:0]        s2_su_reg;
    logic [15:0]        s2_dsize_reg;
    logic               s2_interp_reg;
    logic               s2_attr_reg;
    logic               s2_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_v_reg      <= s1_v_reg;
        s2_lo_reg     <= thr_reg[lo_idx];
        s2_up_reg     <= thr_reg[s1_first_reg];
        s2_sl_reg     <= size_reg[lo_idx];
        s2_su_reg     <= size_reg[s1_first_reg];
        s2_dsize_reg  <= dsize_next;
        s2_interp_reg <= interp_next;
        s2_attr_reg   <= attr_next;
        s2_empty_reg  <= empty_next;
    end

    // Stage 3: distances, span, circle areas and the attribute product.
    logic [31:0]        dl_next;
    logic [31:0]        du_next;
    logic [31:0]        span_next;
    logic [14:0]        hl;
    logic [14:0]        hu;
    logic [29:0]        wl_next;
    logic [29:0]        wu_next;
    logic signed [48:0] aprod_next;

    assign dl_next   = 32'(s2_v_reg - s2_lo_reg);
    assign du_next   = 32'(s2_up_reg - s2_v_reg);
    assign span_next = 32'(s2_up_reg - s2_lo_reg);
    assign hl        = s2_sl_reg[15:1];
    assign hu        = s2_su_reg[15:1];
    assign wl_next   = kind_reg ? (30'(hl) * 30'(hl)) : 30'(s2_sl_reg);
    assign wu_next   = kind_reg ? (30'(hu) * 30'(hu)) : 30'(s2_su_reg);
    assign aprod_next = 49'(s2_v_reg) * 49'($signed({1'b0, scale_reg}));

    logic               s3_valid_reg;
    logic [31:0]        s3_dl_reg;
    logic [31:0]        s3_du_reg;
    logic [31:0]        s3_span_reg;
    logic [29:0]        s3_wl_reg;
    logic [29:0]        s3_wu_reg;
    logic signed [48:0] s3_aprod_reg;
    logic [15:0]        s3_dsize_reg;
    logic               s3_interp_reg;
    logic               s3_attr_reg;
    logic               s3_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // A sample sitting on the lower breakpoint takes the lower size as it is.
    always_ff @(posedge clk)
    begin
        s3_dl_reg     <= dl_next;
        s3_du_reg     <= du_next;
        s3_span_reg   <= span_next;
        s3_wl_reg     <= wl_next;
        s3_wu_reg     <= wu_next;
        s3_aprod_reg  <= aprod_next;
        s3_dsize_reg  <= s2_dsize_reg;
        s3_interp_reg <= s2_interp_reg && (dl_next != '0);
        s3_attr_reg   <= s2_attr_reg;
        s3_empty_reg  <= s2_empty_reg;
    end

    // Stage 4: weighted products and the finished attribute value.
    logic [61:0]  pa_next;
    logic [61:0]  pb_next;
    logic         aneg;
    logic [48:0]  amag;
    logic [48:0]  ash;
    logic [31:0]  attr_res;
    side_t        side_next;

    assign pa_next = 62'(s3_dl_reg) * 62'(s3_wu_reg);
    assign pb_next = 62'(s3_du_reg) * 62'(s3_wl_reg);
    assign aneg    = s3_aprod_reg[48];
    assign amag    = aneg ? 49'(-s3_aprod_reg) : 49'(s3_aprod_reg);
    assign ash     = amag >> ASHIFT;

    // Truncation toward zero, then saturation to the signed 32-bit range.
    always_comb
    begin
        if (!aneg)
        begin
            attr_res = (ash > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : ash[31:0];
        end
        else
        begin
            attr_res = (ash > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-ash[31:0]);
        end
    end

    always_comb
    begin
        side_next.err      = !s3_attr_reg && s3_empty_reg;
        side_next.interp   = s3_interp_reg;
        side_next.kind     = kind_reg;
        side_next.scale_en = !s3_attr_reg && !s3_empty_reg;
        priority if (s3_attr_reg)
        begin
            side_next.direct = attr_res;
        end
        else if (s3_empty_reg)
        begin
            side_next.direct = '0;
        end
        else
        begin
            side_next.direct = 32'(s3_dsize_reg);
        end
    end

    logic         s4_valid_reg;
    logic [61:0]  s4_pa_reg;
    logic [61:0]  s4_pb_reg;
    logic [31:0]  s4_span_reg;
    side_t        s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_pa_reg   <= pa_next;
        s4_pb_reg   <= pb_next;
        s4_span_reg <= s3_span_reg;
        s4_side_reg <= side_next;
    end

    // Blended numerator; the diameter case divides four times the area.
    logic [62:0] psum;
    logic [63:0] num;

    assign psum = 63'(s4_pa_reg) + 63'(s4_pb_reg);
    assign num  = s4_side_reg.kind ? {psum[61:0], 2'b00} : 64'(psum);

    logic         ds_vld;
    side_t        ds_side;
    logic [15:0]  ds_quot;
    logic [15:0]  ds_root;

    psi_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (s4_valid_reg),
        .side_in  (s4_side_reg),
        .num_in   (num),
        .span_in  (s4_span_reg),
        .vld_out  (ds_vld),
        .side_out (ds_side),
        .quot_out (ds_quot),
        .root_out (ds_root)
    );

    // Output stage: Q8.8 scaling of the chosen size.
    logic [15:0] size_sel;
    logic [31:0] scaled;
    logic [31:0] out_next;

    assign size_sel = ds_side.interp ? (ds_side.kind ? ds_root : ds_quot) : ds_side.direct[15:0];
    assign scaled   = (32'(size_sel) * 32'(scale_reg)) >> 8;
    assign out_next = ds_side.scale_en ? scaled : ds_side.direct;

    logic        done_reg;
    logic [31:0] out_reg;
    logic        err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ds_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        err_reg <= ds_side.err;
    end

    assign done        = done_reg;
    assign out_size    = $signed(out_reg);
    assign empty_error = err_reg;

    // An empty-table result carries a zero size.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty_error) |-> (out_size == 32'sd0))
        else $error("empty table result with nonzero size");

    // Attribute mode never reports an empty table.
    a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty_error) |-> (mode_reg != MODE_ATTR))
        else $error("empty table flagged in attribute mode");

    // Table-driven sizes are never negative.
    a_size_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mode_reg != MODE_ATTR)) |-> !out_size[31])
        else $error("negative size outside attribute mode");

endmodule

FILE: tb/psi_checker.sv
// Checker for the piecewise size interpolator: watches requests, predicts sizes, compares.
`timescale 1ns / 1ps

module psi_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            opcode,
    input  logic [2:0]                      entry_index,
    input  logic signed [31:0]              entry_threshold,
    input  logic [15:0]                     entry_size,
    input  logic signed [31:0]              sample_value,
    input  logic                            cfg_write,
    input  logic [psi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            done,
    input  logic signed [31:0]              out_size,
    input  logic                            empty_error,
    output int                              failures,
    output int                              outstanding
);
    import psi_pkg::*;

    localparam int DEPTH = 8;

    typedef struct packed {
        logic signed [31:0] size;
        logic               err;
    } size_result_t;

    // Shadow copy of the table and the configuration.
    logic signed [31:0] thr_shadow [DEPTH];
    logic [15:0]        size_shadow [DEPTH];
    logic [1:0]         mode_q;
    logic               kind_q;
    logic [15:0]        scale_q;
    logic [3:0]         count_q;

    size_result_t sizes_due [$];

    // Integer square root, bit by bit.
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a table size by the Q8.8 factor and saturates.
    function automatic logic [31:0] apply_scale(input logic [63:0] sz);
        logic [63:0] p;
        p = (sz * scale_q) >> 8;
        if (p > 64'h7FFF_FFFF)
            p = 64'h7FFF_FFFF;
        return p[31:0];
    endfunction

    // Blends the sizes of two breakpoints around the sample.
    function automatic logic [63:0] blend(input longint v, input longint lo, input longint up,
                                          input logic [63:0] sl, input logic [63:0] su);
        logic [63:0] dl, du, span, al, au, num, q, r;
        if (mode_q == MODE_DISCRETE || v <= lo)
            return sl;
        if (v >= up)
            return su;
        dl = v - lo;
        du = up - v;
        span = up - lo;
        if (!kind_q)
            return (dl * su + du * sl) / span;
        al = (sl / 2) * (sl / 2);
        au = (su / 2) * (su / 2);
        num = dl * au + du * al;
        q = num / span;
        r = num % span;
        return int_sqrt(4 * q + (4 * r) / span);
    endfunction

    // Expected result of one classify request.
    function automatic size_result_t predict_size(input logic signed [31:0] sample);
        size_result_t res;
        longint v, p, mag;
        int n;
        logic [63:0] sz;
        logic hit;
        res = '0;
        v = sample;
        if (mode_q == MODE_ATTR)
        begin
            p = v * longint'(scale_q);
            mag = (p < 0) ? -p : p;
            mag = mag >>> 24;
            if (p >= 0)
                res.size = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            else
                res.size = (mag > 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
            return res;
        end
        n = (count_q > DEPTH) ? DEPTH : count_q;
        if (n == 0)
        begin
            res.err = 1'b1;
            return res;
        end
        if (mode_q == MODE_CONST)
        begin
            res.size = apply_scale(size_shadow[0]);
            return res;
        end
        hit = 1'b0;
        sz = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && v < longint'(thr_shadow[i]))
            begin
                hit = 1'b1;
                if (i == 0)
                    sz = size_shadow[0];
                else
                    sz = blend(v, thr_shadow[i-1], thr_shadow[i],
                               size_shadow[i-1], size_shadow[i]);
            end
        end
        if (!hit)
            sz = size_shadow[n-1];
        res.size = apply_scale(sz);
        return res;
    endfunction

    assign outstanding = sizes_due.size();

    // Track requests, configuration writes and results.
    always @(posedge clk or negedge rst_n)
    begin
        size_result_t exp_res;
        if (!rst_n)
        begin
            mode_q   <= MODE_DISCRETE;
            kind_q   <= 1'b0;
            scale_q  <= 16'd256;
            count_q  <= 4'd0;
            failures <= 0;
            sizes_due.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:  mode_q  <= cfg_data[1:0];
                    REG_KIND:  kind_q  <= cfg_data[0];
                    REG_SCALE: scale_q <= cfg_data;
                    REG_COUNT: count_q <= cfg_data[3:0];
                endcase
            end
            if (start && !busy)
            begin
                if (opcode == OP_WRITE)
                begin
                    thr_shadow[entry_index]  <= entry_threshold;
                    size_shadow[entry_index] <= entry_size;
                end
                else
                    sizes_due = {sizes_due, predict_size(sample_value)};
            end
            if (done)
            begin
                if (sizes_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("ERROR: unexpected result size=%0d err=%0b",
                                 out_size, empty_error);
                    failures <= failures + 1;
                end
                else
                begin
                    exp_res = sizes_due.pop_front();
                    if (exp_res.size !== out_size || exp_res.err !== empty_error)
                    begin
                        if (failures < 10)
                            $display("ERROR: size exp %0d got %0d, err exp %0b got %0b",
                                     exp_res.size, out_size, exp_res.err, empty_error);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the piecewise size interpolator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import psi_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  opcode;
    logic [2:0]            entry_index;
    logic signed [31:0]    entry_threshold;
    logic [15:0]           entry_size;
    logic signed [31:0]    sample_value;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic signed [31:0]    out_size;
    logic                  empty_error;
    int                    failures;
    int                    outstanding;
    int                    cycles = 0;

    // Stimulus-side view of the thresholds, used to aim samples near breakpoints.
    logic signed [31:0]    thr_view [8];

    piecewise_size_interpolator_core DUT (.*);

    psi_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Writes one configuration register; leaves the port idle afterward.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Sends one request after a random gap and waits until it is taken.
    task automatic send_request(input logic op, input logic [2:0] idx,
                                input logic [31:0] thr, input logic [15:0] sz,
                                input logic [31:0] val);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        opcode          <= op;
        entry_index     <= idx;
        entry_threshold <= thr;
        entry_size      <= sz;
        sample_value    <= val;
        if (op == OP_WRITE)
            thr_view[idx] = thr;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic classify(input logic [31:0] val);
        send_request(OP_CLASSIFY, 3'($urandom), $urandom, 16'($urandom), val);
    endtask

    task automatic load_entry(input logic [2:0] idx, input logic [31:0] thr,
                              input logic [15:0] sz);
        send_request(OP_WRITE, idx, thr, sz, $urandom);
    endtask

    // Lets every request drain before the configuration changes.
    task automatic drain_requests();
        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_config(input int mode, input int kind, input int scale, input int cnt);
        drain_requests();
        write_reg(REG_MODE, mode);
        write_reg(REG_KIND, kind);
        write_reg(REG_SCALE, scale);
        write_reg(REG_COUNT, cnt);
    endtask

    // A random sample: fully random, at an extreme of the range, or close to a breakpoint.
    function automatic logic [31:0] pick_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return $urandom;
        if (k == 4)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return thr_view[$urandom_range(0, 7)] + $signed($urandom_range(0, 64)) - 32;
    endfunction

    // A random threshold, sometimes at the extremes.
    function automatic logic [31:0] pick_threshold();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 32'h8000_0000;
        if (k == 1)
            return 32'h7FFF_FFFF;
        if (k < 5)
            return $signed($urandom_range(0, 40000)) - 20000;
        return $urandom;
    endfunction

    initial
    begin
        int mode, cnt, scale, n_items;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_CLASSIFY;
        entry_index = '0;
        entry_threshold = '0;
        entry_size = '0;
        sample_value = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table right after reset, then the full table, ascending.
        classify(32'h0001_0000);
        load_entry(3'd0, 32'h8000_0000, 16'd0);
        load_entry(3'd1, 32'hFFFF_0000, 16'd10);
        load_entry(3'd2, 32'h0000_0000, 16'd65535);
        load_entry(3'd3, 32'h0001_0000, 16'd3);
        load_entry(3'd4, 32'h0004_0000, 16'd200);
        load_entry(3'd5, 32'h0100_0000, 16'd1000);
        load_entry(3'd6, 32'h1000_0000, 16'd7);
        load_entry(3'd7, 32'h7FFF_FFFF, 16'd65535);

        // Attribute scaling at the extremes of the sample.
        set_config(MODE_ATTR, 0, 65535, 0);
        classify(32'h7FFF_FFFF);
        classify(32'h8000_0000);
        classify(32'hFFFF_FFFF);

        // Linear height: on the first breakpoint, on and between breakpoints, on the last.
        set_config(MODE_LINEAR, 0, 256, 8);
        classify(32'h8000_0000);
        classify(32'hFFFF_8000);
        classify(32'h0000_0000);
        classify(32'h0002_0000);
        classify(32'h7FFF_FFFF);

        // Diameter mode with an oversized count, then constant and discrete.
        set_config(MODE_LINEAR, 1, 65535, 15);
        classify(32'hFFFF_8000);
        classify(32'h0000_8000);
        set_config(MODE_CONST, 1, 0, 3);
        classify(32'h1234_5678);
        set_config(MODE_DISCRETE, 0, 384, 8);
        classify(32'h0003_0000);
        classify(32'h7FFF_FFFF);

        // Random phases; the table stays fully written, so every entry is defined.
        for (int ph = 0; ph < 13; ph++)
        begin
            mode = $urandom_range(0, 3);
            cnt = (ph % 4 == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            scale = (ph == 1) ? 0 : (ph == 2) ? 65535 : $urandom_range(0, 1023);
            set_config(mode, $urandom_range(0, 1), scale, cnt);
            n_items = 52;
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                    load_entry(3'($urandom), pick_threshold(),
                               $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
                else
                    classify(pick_sample());
            end
        end

        drain_requests();
        if (failures == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
